>>> rtl/core/pda_pkg.sv
// Shared types and constants for the PWM period and duty analyser.
`timescale 1ns / 1ps
`default_nettype none

package pda_pkg;

    // Capture timer width and result field widths
    localparam int CNT_W  = 24;
    localparam int CLK_W  = 28;
    localparam int DUTY_W = 7;

    // Shared divider: dividend and quotient width, step counter width
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Duty scale and saturation limit
    localparam logic [DUTY_W-1:0] PCT_SCALE = DUTY_W'(100);

    // Tick rate after reset
    localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(80000000);

    typedef struct packed {
        logic             edge_rising;
        logic [CNT_W-1:0] capture_time;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]  period_ticks;
        logic [CNT_W-1:0]  high_ticks;
        logic [CLK_W-1:0]  frequency_hz;
        logic [DUTY_W-1:0] duty_percent;
        logic              measure_error;
    } out_item_t;

    // Handshake between the sequencer and the shared divider
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/pda_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pda_divider
    import pda_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    typedef enum logic {
        DV_IDLE,
        DV_RUN
    } dv_state_t;

    dv_state_t            state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     divisor_reg, divisor_next;

    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       diff;

    // Bring down the next dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    quo_next     = req.dividend;
                    rem_next     = '0;
                    divisor_next = req.divisor;
                    cnt_next     = DIV_CNT_W'(DIV_W - 1);
                    state_next   = DV_RUN;
                end
            end
            DV_RUN:
            begin
                // Keep the difference when there is no borrow
                if (!diff[CNT_W])
                begin
                    rem_next = diff[CNT_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[CNT_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // Partial remainder stays below the divisor after the first step of a run
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DV_RUN) && (cnt_reg != DIV_CNT_W'(DIV_W - 1)) |-> rem_reg < divisor_reg)
        else $error("divider remainder not below divisor");

    // Completion is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    // Completion only follows the last step of a run
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == DV_RUN) && $past(cnt_reg == '0))
        else $error("divider done without a finished run");

endmodule

`default_nettype wire

>>> rtl/core/pwm_period_duty_analyser.sv
// Top level of the PWM period and duty analyser: capture state, sequencer, output register.
`timescale 1ns / 1ps
`default_nettype none

// The block takes capture events from a down-counting 24-bit capture timer, each
// an edge polarity and the latched timer value, and keeps the last rising and
// falling timestamps. A rising edge that follows a rise and a fall yields one
// result: period and high time as modular differences of the timer, the
// frequency clock_hz / period, and the duty high * 100 / period saturated at
// 100. A zero period or a high time above the period sets measure_error and
// forces frequency and duty to zero. A falling edge, or a rising edge that
// closes no measurement, leaves the block idle. A rising edge that closes a
// measurement runs two 32-step divisions on one shared restoring divider; an
// erroneous measurement skips both divisions and goes from ST_CHECK straight
// to ST_OUT. in_stall is held high during that work. The finished result
// waits in an output register, so the next edge can be taken while the result
// is still stalled downstream.
// clock_hz is written through the cfg port, which is always ready, and should
// change only while the block is idle.
module pwm_period_duty_analyser
    import pda_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CLK_W-1:0] cfg_data,

    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_data,

    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FREQ,
        ST_DUTY,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [CLK_W-1:0]  clock_hz_reg, clock_hz_next;
    logic [CNT_W-1:0]  rise_time_reg, rise_time_next;
    logic [CNT_W-1:0]  fall_time_reg, fall_time_next;
    logic              rise_seen_reg, rise_seen_next;
    logic              fall_seen_reg, fall_seen_next;
    logic [CNT_W-1:0]  period_reg, period_next;
    logic [CNT_W-1:0]  high_reg, high_next;
    logic              err_reg, err_next;
    logic [CLK_W-1:0]  freq_reg, freq_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic              div_start_reg, div_start_next;
    logic [DIV_W-1:0]  div_dividend_reg, div_dividend_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              in_xfer;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dividend_reg;
    assign div_req.divisor  = period_reg;

    pda_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next        = state_reg;
        clock_hz_next     = clock_hz_reg;
        rise_time_next    = rise_time_reg;
        fall_time_next    = fall_time_reg;
        rise_seen_next    = rise_seen_reg;
        fall_seen_next    = fall_seen_reg;
        period_next       = period_reg;
        high_next         = high_reg;
        err_next          = err_reg;
        freq_next         = freq_reg;
        duty_next         = duty_reg;
        div_start_next    = 1'b0;
        div_dividend_next = div_dividend_reg;
        // Drop the held result once downstream takes it
        out_valid_next    = out_valid_reg && out_stall;
        out_data_next     = out_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            clock_hz_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!in_data.edge_rising)
                    begin
                        // Ignore a fall before any rise; keep only the last fall
                        if (rise_seen_reg)
                        begin
                            fall_time_next = in_data.capture_time;
                            fall_seen_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (rise_seen_reg && fall_seen_reg)
                        begin
                            // Timer counts down: earlier minus later, mod counter width
                            period_next = rise_time_reg - in_data.capture_time;
                            high_next   = rise_time_reg - fall_time_reg;
                            state_next  = ST_CHECK;
                        end
                        rise_time_next = in_data.capture_time;
                        rise_seen_next = 1'b1;
                        fall_seen_next = 1'b0;
                    end
                end
            end
            ST_CHECK:
            begin
                err_next = (period_reg == '0) || (high_reg > period_reg);
                if ((period_reg == '0) || (high_reg > period_reg))
                begin
                    freq_next  = '0;
                    duty_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start_next    = 1'b1;
                    div_dividend_next = DIV_W'(clock_hz_reg);
                    state_next        = ST_FREQ;
                end
            end
            ST_FREQ:
            begin
                if (div_rsp.done)
                begin
                    // Quotient never exceeds clock_hz, so the low bits hold it
                    freq_next         = div_rsp.quotient[CLK_W-1:0];
                    div_start_next    = 1'b1;
                    div_dividend_next = DIV_W'(high_reg) * DIV_W'(PCT_SCALE);
                    state_next        = ST_DUTY;
                end
            end
            ST_DUTY:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > DIV_W'(PCT_SCALE))
                    begin
                        duty_next = PCT_SCALE;
                    end
                    else
                    begin
                        duty_next = div_rsp.quotient[DUTY_W-1:0];
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.period_ticks  = period_reg;
                    out_data_next.high_ticks    = high_reg;
                    out_data_next.frequency_hz  = freq_reg;
                    out_data_next.duty_percent  = duty_reg;
                    out_data_next.measure_error = err_reg;
                    out_valid_next              = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clock_hz_reg  <= CLK_RESET;
            rise_time_reg <= '0;
            fall_time_reg <= '0;
            rise_seen_reg <= 1'b0;
            fall_seen_reg <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clock_hz_reg  <= clock_hz_next;
            rise_time_reg <= rise_time_next;
            fall_time_reg <= fall_time_next;
            rise_seen_reg <= rise_seen_next;
            fall_seen_reg <= fall_seen_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg       <= period_next;
        high_reg         <= high_next;
        err_reg          <= err_next;
        freq_reg         <= freq_next;
        duty_reg         <= duty_next;
        div_dividend_reg <= div_dividend_next;
        out_data_reg     <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A flagged measurement carries no frequency and no duty
    a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.measure_error |->
            (out_data.frequency_hz == '0) && (out_data.duty_percent == '0))
        else $error("error result with nonzero frequency or duty");

    // Duty never goes past full scale
    a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.duty_percent <= PCT_SCALE)
        else $error("duty above full scale");

    // A fall record only exists after a rise
    a_fall_needs_rise: assert property (@(posedge clk) disable iff (!rst_n)
        fall_seen_reg |-> rise_seen_reg)
        else $error("fall recorded without a prior rise");

endmodule

`default_nettype wire

>>> verif/tb_pwm_period_duty_analyser.sv
// Testbench for the PWM period and duty analyser: directed capture table, random streams, scoreboard.
`timescale 1ns / 1ps

// Drive capture events into the analyser and check every measurement it returns.
// A behavioral predictor tracks the last rise and fall timestamps and works out
// period, high time, frequency and duty for each rise that closes a measurement.
// The run is a directed table walked by a loop, then six random phases. Each
// random phase starts with a new clock_hz: 1, 200 MHz, all ones, zero, a random
// value, and the reset value again. The sender and the receiver idle at random,
// first 30/60 percent, then 60/30, then not at all. Once, the receiver holds off
// for a long stretch so that the block fills up and stalls its input.
module tb_pwm_period_duty_analyser;
    import pda_pkg::*;

    localparam int N_DIRECTED    = 23;
    localparam int N_PHASES      = 6;
    localparam int PHASE_EDGES   = 180;
    // Leave ample room for the block to go idle after a measurement
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_AT_EDGE  = 250;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_MAX    = 10;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic             rising;
        logic [CNT_W-1:0] stamp;
        logic             typed;
        logic             yields;
        out_item_t        want;
    } capture_row_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CLK_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_item_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_data;

    // Predictor state: tick rate and the capture timestamps seen so far
    logic [CLK_W-1:0] tick_rate_hz = CLK_RESET;
    logic [CNT_W-1:0] last_rise    = '0;
    logic [CNT_W-1:0] last_fall    = '0;
    logic             rise_held    = 1'b0;
    logic             fall_held    = 1'b0;

    // Measurements still owed by the block, oldest first
    out_item_t        measurements_due[$];

    int unsigned      mismatches        = 0;
    int unsigned      edges_taken       = 0;
    int unsigned      cycle_count       = 0;
    int unsigned      sender_idle_pct   = 30;
    int unsigned      receiver_idle_pct = 60;
    int unsigned      hold_left         = 0;
    logic             hold_done         = 1'b0;
    // Last rising timestamp sent, so random streams can build well-formed periods
    logic [CNT_W-1:0] stream_rise       = '0;

    pwm_period_duty_analyser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Advance the predictor by one capture event; return the measurement it closes, if any
    task automatic measure_capture(input in_item_t ev, output logic yields,
                                   output out_item_t res);
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] high;
        logic [63:0]      duty;
        begin
            yields = 1'b0;
            res    = '0;
            if (!ev.edge_rising)
            begin
                // Drop a fall that comes before any rise; keep only the latest fall
                if (rise_held)
                begin
                    last_fall = ev.capture_time;
                    fall_held = 1'b1;
                end
            end
            else
            begin
                if (rise_held && fall_held)
                begin
                    // Timer counts down: elapsed ticks are earlier minus later, modulo 2^24
                    period           = last_rise - ev.capture_time;
                    high             = last_rise - last_fall;
                    res.period_ticks = period;
                    res.high_ticks   = high;
                    if (period == '0 || high > period)
                        res.measure_error = 1'b1;
                    else
                    begin
                        res.frequency_hz = tick_rate_hz / period;
                        duty             = (64'(high) * 64'd100) / 64'(period);
                        res.duty_percent = (duty > 64'(PCT_SCALE)) ? PCT_SCALE
                                                                   : DUTY_W'(duty);
                    end
                    yields = 1'b1;
                end
                // Every rise becomes the new reference and reopens the high-time window
                last_rise = ev.capture_time;
                rise_held = 1'b1;
                fall_held = 1'b0;
            end
        end
    endtask

    // Offer one capture event, wait for its transfer, then log what it should produce.
    // A typed row overrides the predicted outcome with the value from the table.
    task automatic send_capture(input in_item_t ev, input logic typed,
                                input logic typed_yields, input out_item_t typed_want);
        logic      yields;
        out_item_t res;
        begin
            while ($urandom_range(99) < sender_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= ev;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            edges_taken++;
            if (ev.edge_rising)
                stream_rise = ev.capture_time;
            measure_capture(ev, yields, res);
            if (typed)
            begin
                yields = typed_yields;
                res    = typed_want;
            end
            if (yields)
                measurements_due.push_back(res);
        end
    endtask

    // Drop valid, wait for every owed measurement, then let the block settle
    task automatic drain_block();
        begin
            in_valid <= 1'b0;
            while (measurements_due.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_tick_rate(input logic [CLK_W-1:0] hz);
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= hz;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            tick_rate_hz = hz;
        end
    endtask

    // Random capture stream: mostly well-formed fall/rise pairs built off the last
    // rise, plus double rises, noise and zero periods
    task automatic send_stream(input int unsigned count);
        int unsigned      start_edges;
        int unsigned      pick;
        int unsigned      width;
        int unsigned      falls;
        logic [CNT_W-1:0] mask;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] high;
        begin
            start_edges = edges_taken;
            // Open with a rise so the first pair has a reference
            send_capture(in_item_t'({1'b1, CNT_W'($urandom)}), 1'b0, 1'b0, '0);
            while (edges_taken - start_edges < count)
            begin
                pick   = $urandom_range(99);
                // Spread magnitudes over every width, not just near-full-scale values
                width  = $urandom_range(CNT_W, 1);
                mask   = CNT_W'((64'd1 << width) - 64'd1);
                period = CNT_W'($urandom) & mask;
                if (pick < 75)
                begin
                    falls = ($urandom_range(9) == 0) ? $urandom_range(3, 2) : 1;
                    repeat (falls)
                    begin
                        // Mostly a high time within the period; now and then one beyond it
                        if ($urandom_range(9) == 0)
                            high = CNT_W'($urandom) & mask;
                        else
                            high = CNT_W'((64'($urandom) * (64'(period) + 64'd1)) >> 32);
                        send_capture(in_item_t'({1'b0, stream_rise - high}),
                                     1'b0, 1'b0, '0);
                    end
                    send_capture(in_item_t'({1'b1, stream_rise - period}), 1'b0, 1'b0, '0);
                end
                else if (pick < 85)
                    send_capture(in_item_t'({1'b1, CNT_W'($urandom)}), 1'b0, 1'b0, '0);
                else if (pick < 95)
                    send_capture(in_item_t'({1'($urandom), CNT_W'($urandom)}),
                                 1'b0, 1'b0, '0);
                else
                begin
                    // Rise at the same timestamp as the reference: zero period
                    send_capture(in_item_t'({1'b0, stream_rise - period}), 1'b0, 1'b0, '0);
                    send_capture(in_item_t'({1'b1, stream_rise}), 1'b0, 1'b0, '0);
                end
            end
        end
    endtask

    // Receiver: random stall, plus one long hold-off once enough edges are in
    always @(posedge clk)
    begin
        if (!hold_done && edges_taken >= HOLD_AT_EDGE)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    function automatic void note_mismatch(input string what, input out_item_t want,
                                          input out_item_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t %s: want p=%0d h=%0d f=%0d d=%0d e=%0b got p=%0d h=%0d f=%0d d=%0d e=%0b",
                     $realtime, what, want.period_ticks, want.high_ticks, want.frequency_hz,
                     want.duty_percent, want.measure_error, got.period_ticks,
                     got.high_ticks, got.frequency_hz, got.duty_percent, got.measure_error);
    endfunction

    // Scoreboard: check each result transfer against the oldest owed measurement
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (measurements_due.size() == 0)
                note_mismatch("unexpected result", '0, out_data);
            else
            begin
                want = measurements_due.pop_front();
                if (out_data.period_ticks !== want.period_ticks
                    || out_data.high_ticks !== want.high_ticks
                    || out_data.frequency_hz !== want.frequency_hz
                    || out_data.duty_percent !== want.duty_percent
                    || out_data.measure_error !== want.measure_error)
                    note_mismatch("mismatch", want, out_data);
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        capture_row_t     directed_rows [N_DIRECTED];
        logic [CLK_W-1:0] rate_plan [N_PHASES];
        int unsigned      k;

        // Directed captures at the reset tick rate of 80 MHz
        directed_rows = '{
            // fall before any rise: ignored
            '{1'b0, 24'h123456, 1'b1, 1'b0, '0},
            // first rise: reference only
            '{1'b1, 24'hFFFFFF, 1'b1, 1'b0, '0},
            '{1'b0, 24'hFFFFFF, 1'b0, 1'b0, '0},
            // rise at the reference timestamp: zero period flags an error
            '{1'b1, 24'hFFFFFF, 1'b1, 1'b1, '{24'd0, 24'd0, 28'd0, 7'd0, 1'b1}},
            '{1'b0, 24'hFFFF00, 1'b0, 1'b0, '0},
            '{1'b1, 24'hFFFE00, 1'b0, 1'b0, '0},
            // two rises with no fall between: no result, new reference
            '{1'b1, 24'h000100, 1'b1, 1'b0, '0},
            // fall and rise after the timer wraps through zero
            '{1'b0, 24'hFFFF80, 1'b0, 1'b0, '0},
            '{1'b1, 24'hFFFF00, 1'b0, 1'b0, '0},
            // several falls: the last one sets the high time
            '{1'b0, 24'hFFFE80, 1'b0, 1'b0, '0},
            '{1'b0, 24'hFFFD00, 1'b0, 1'b0, '0},
            '{1'b0, 24'hFFFC80, 1'b0, 1'b0, '0},
            '{1'b1, 24'hFFFB00, 1'b0, 1'b0, '0},
            // high time above the period: error, raw differences still reported
            '{1'b0, 24'hFFF000, 1'b0, 1'b0, '0},
            '{1'b1, 24'hFFF800, 1'b1, 1'b1, '{24'h000300, 24'h000B00, 28'd0, 7'd0, 1'b1}},
            // period of one tick, zero high time: frequency equals the tick rate
            '{1'b0, 24'hFFF800, 1'b0, 1'b0, '0},
            '{1'b1, 24'hFFF7FF, 1'b1, 1'b1, '{24'd1, 24'd0, 28'd80000000, 7'd0, 1'b0}},
            // high time equal to a one-tick period: full duty
            '{1'b0, 24'hFFF7FE, 1'b0, 1'b0, '0},
            '{1'b1, 24'hFFF7FE, 1'b1, 1'b1, '{24'd1, 24'd1, 28'd80000000, 7'd100, 1'b0}},
            // longest period and high time
            '{1'b0, 24'hFFF7FF, 1'b0, 1'b0, '0},
            '{1'b1, 24'hFFF7FF, 1'b1, 1'b1,
              '{24'hFFFFFF, 24'hFFFFFF, 28'd4, 7'd100, 1'b0}},
            // all-zero timestamps
            '{1'b0, 24'h000000, 1'b0, 1'b0, '0},
            '{1'b1, 24'h000000, 1'b0, 1'b0, '0}
        };

        // Tick rates per random phase: extremes, zero, a random one, back to reset
        rate_plan = '{CLK_W'(1), CLK_W'(200000000), '1, '0,
                      CLK_W'($urandom_range(200000000, 1)), CLK_RESET};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < N_DIRECTED; k++)
            send_capture(in_item_t'({directed_rows[k].rising, directed_rows[k].stamp}),
                         directed_rows[k].typed, directed_rows[k].yields,
                         directed_rows[k].want);

        for (k = 0; k < N_PHASES; k++)
        begin
            drain_block();
            write_tick_rate(rate_plan[k]);
            // Idle mix per pair of phases: sender-light, receiver-light, then none
            case (k / 2)
                0:
                begin
                    sender_idle_pct   = 30;
                    receiver_idle_pct <= 60;
                end
                1:
                begin
                    sender_idle_pct   = 60;
                    receiver_idle_pct <= 30;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct <= 0;
                end
            endcase
            send_stream(PHASE_EDGES);
        end

        drain_block();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
